// ===== design/trial_division_prime_test_top_macros.svh =====
// Assertion macros for the trial-division prime test block
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// check while out of reset
`define TDPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define TDPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tdpt_pkg.sv =====
// Shared constants and types for the trial-division prime test block
`default_nettype none
package tdpt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam value_t VAL_TWO   = value_t'(2);
  localparam value_t VAL_THREE = value_t'(3);
  localparam value_t VAL_FOUR  = value_t'(4);
  localparam cnt_t   CNT_LAST  = cnt_t'(VALUE_BITS - 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== design/tdpt_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none
module tdpt_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire tdpt_pkg::value_t dividend,
  input  wire tdpt_pkg::value_t divisor,
  output tdpt_pkg::div_status_t status,
  output tdpt_pkg::value_t     quotient,
  output tdpt_pkg::value_t     remainder
);
  import tdpt_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  cnt_t             cnt_r, cnt_nxt;
  value_t           dvd_r, dvd_nxt;
  value_t           dsr_r, dsr_nxt;
  value_t           rem_r, rem_nxt;
  logic [VALUE_BITS:0] trial;
  logic [VALUE_BITS:0] diff;
  logic             fits;

  assign trial = {rem_r, dvd_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], fits};
      cnt_nxt = cnt_r + cnt_t'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = dvd_r;
  assign remainder   = rem_r;

endmodule
`default_nettype wire

// ===== design/trial_division_prime_test_top.sv =====
// Trial-division primality test: top level with control and result register
// Usage:
//   Input channel in_valid/in_stall carries in_number; a transfer happens at a
//   clock edge with in_valid high and in_stall low. One result per number is
//   sent on out_valid/out_stall with out_prime_flag and out_tested_number.
//   Zero, one, two, three and even numbers are decided without division; they
//   pass through the finish state to the output register. Other numbers are
//   divided by 3, 5, 7 and so on in turn on a bit-serial divider; testing
//   ends at the first divisor or once the candidate exceeds the quotient.
//   The divider loop sets throughput: one number is worked on at a time, and
//   in_stall is high while it is. The output register holds a result until
//   it is taken; the next number is accepted while it waits. A held result
//   blocks only the finish of the following number. Reset (rst_n low,
//   synchronous) drops any work in flight and clears out_valid.
`default_nettype none
module trial_division_prime_test_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire tdpt_pkg::value_t in_number,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_prime_flag,
  output tdpt_pkg::value_t  out_tested_number
);
  import tdpt_pkg::*;
  `include "trial_division_prime_test_top_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t      state_r, state_nxt;
  value_t      num_r, num_nxt;
  value_t      d_r, d_nxt;
  logic        start_r, start_nxt;
  logic        prime_r, prime_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_prime_flag_r, out_prime_flag_nxt;
  value_t      out_tested_number_r, out_tested_number_nxt;
  div_status_t div_status;
  value_t      div_quot;
  value_t      div_rem;
  logic        slot_free;

  tdpt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (num_r),
    .divisor   (d_r),
    .status    (div_status),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt             = state_r;
    num_nxt               = num_r;
    d_nxt                 = d_r;
    start_nxt             = 1'b0;
    prime_nxt             = prime_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_prime_flag_nxt    = out_prime_flag_r;
    out_tested_number_nxt = out_tested_number_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          num_nxt = in_number;
          priority if (in_number < VAL_TWO) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else if (in_number < VAL_FOUR) begin
            prime_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else if (!in_number[0]) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            d_nxt     = VAL_THREE;
            start_nxt = 1'b1;
            state_nxt = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        if (div_status.done) begin
          priority if (d_r > div_quot) begin
            prime_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else if (div_rem == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            d_nxt     = d_r + VAL_TWO;
            start_nxt = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_prime_flag_nxt    = prime_r;
          out_tested_number_nxt = num_r;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r               <= num_nxt;
    d_r                 <= d_nxt;
    prime_r             <= prime_nxt;
    out_prime_flag_r    <= out_prime_flag_nxt;
    out_tested_number_r <= out_tested_number_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_prime_flag    = out_prime_flag_r;
  assign out_tested_number = out_tested_number_r;

  `TDPT_ASSERT(a_start_idle_div, start_r |-> !div_status.busy, "divider started while busy")
  `TDPT_ASSERT(a_odd_divisor, (state_r == S_DIVIDE) |-> d_r[0], "even trial divisor")
  `TDPT_ASSERT(a_prime_ge_two, (out_valid_r && out_prime_flag_r) |-> (out_tested_number_r >= VAL_TWO), "value below two flagged prime")
  `TDPT_ASSERT(a_even_prime_two, (out_valid_r && out_prime_flag_r && !out_tested_number_r[0]) |-> (out_tested_number_r == VAL_TWO), "even value above two flagged prime")
  `TDPT_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule
`default_nettype wire
